// ===== hdl/iucc_pkg.sv =====
// shared types, constants and the crc byte function for the image crc checker
`timescale 1ns / 1ps

package iucc_pkg;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 32;
    localparam int COUNT_W = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC = 2'd1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHUNK_ACK = 2'd0,
        KIND_MISMATCH  = 2'd1,
        KIND_MATCH     = 2'd2
    } kind_t;

    // one queued result
    typedef struct packed {
        kind_t            kind;
        logic [CRC_W-1:0] crc;
        logic             last;
    } result_t;

    // table entry of the reflected crc-32 for one byte index
    function automatic logic [CRC_W-1:0] crc_tab(input logic [BYTE_W-1:0] idx);
        logic [CRC_W-1:0] r;
        r = {{(CRC_W-BYTE_W){1'b0}}, idx};
        for (int k = 0; k < BYTE_W; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/image_upload_crc32_checker.sv =====
// top level: streaming crc-32 check of an uploaded image with chunk acknowledges
//
//  channel  | ports          | tdata                   | tuser     | tlast
//  ---------+----------------+-------------------------+-----------+--------------
//  input    | s_t*           | [7:0] data_byte         | -         | -
//  result   | m_t*           | [31:0] crc_value        | [1:0] kind| last
//  config   | cfg_*          | cfg_data [31:0] value   | cfg_index | -
//
//  one byte is accepted per cycle while s_tready is high; its crc and counters are updated
//  in the cycle after, from the input register into a four-entry result queue
//  a byte's first result passes the input register and the queue before it can transfer
//  the last byte of an image gives two results, drained one per cycle when m_tready is set
//  s_tready drops while the queue plus what the byte in flight pushes leaves < 2 free slots
//  synchronous active-low reset; no clearing pass is needed
`timescale 1ns / 1ps

module image_upload_crc32_checker
    import iucc_pkg::*;
#(
    parameter int CHUNK_BYTES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input byte stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,    // [7:0] data_byte
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CRC_W-1:0]     m_tdata,    // [31:0] crc_value
    output logic [1:0]           m_tuser,    // [1:0] kind
    output logic                 m_tlast,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CRC_W-1:0]     cfg_data
);

    localparam int CHUNK_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNK_BYTES - 1);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // configuration registers
    logic [COUNT_W-1:0] image_size_reg;
    logic [CRC_W-1:0]   expected_crc_reg;

    // input register
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;

    // running state
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [COUNT_W-1:0] bytes_reg, bytes_next;
    logic [CHUNK_W-1:0] chunk_cnt_reg, chunk_cnt_next;

    // result queue
    result_t            queue_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  q_count_reg, q_count_next;

    logic               s_xfer, m_xfer;
    logic [CRC_W-1:0]   crc_upd, crc_final;
    logic [COUNT_W-1:0] count_upd;
    logic               done, chunk_end;
    logic [1:0]         n_push;
    result_t            res0, res1;
    logic [QCNT_W-1:0]  inflight;

    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // configuration write; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg   <= COUNT_W'(1);
            expected_crc_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IMAGE_SIZE) begin
                image_size_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cfg_index == CFG_EXPECTED_CRC) begin
                expected_crc_reg <= cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_tdata;
        end
    end

    // byte crc update, count and chunk tests
    always_comb begin
        crc_upd   = (crc_reg >> 8) ^ crc_tab(crc_reg[BYTE_W-1:0] ^ in_byte_reg);
        crc_final = ~crc_upd;
        count_upd = bytes_reg + COUNT_W'(1);
        done      = (count_upd >= image_size_reg);
        chunk_end = (chunk_cnt_reg == CHUNK_LAST);

        res0.kind = KIND_CHUNK_ACK;
        res0.crc  = crc_upd;
        res0.last = !done;
        res1.kind = (expected_crc_reg != '0 && expected_crc_reg != crc_final)
                    ? KIND_MISMATCH : KIND_MATCH;
        res1.crc  = crc_final;
        res1.last = 1'b1;

        crc_next       = crc_reg;
        bytes_next     = bytes_reg;
        chunk_cnt_next = chunk_cnt_reg;
        n_push         = 2'd0;
        if (in_valid_reg) begin
            if (done) begin
                crc_next       = CRC_PRESET;
                bytes_next     = '0;
                chunk_cnt_next = '0;
                n_push         = 2'd2;
            end else begin
                crc_next       = crc_upd;
                bytes_next     = count_upd;
                chunk_cnt_next = chunk_end ? '0 : chunk_cnt_reg + CHUNK_W'(1);
                n_push         = chunk_end ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_PRESET;
            bytes_reg     <= '0;
            chunk_cnt_reg <= '0;
        end else begin
            crc_reg       <= crc_next;
            bytes_reg     <= bytes_next;
            chunk_cnt_reg <= chunk_cnt_next;
        end
    end

    // result queue pointers and fill count
    assign q_count_next = q_count_reg + QCNT_W'(n_push) - QCNT_W'(m_xfer);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_reg + QPTR_W'(n_push);
            rd_ptr_reg  <= rd_ptr_reg + QPTR_W'(m_xfer);
            q_count_reg <= q_count_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (n_push == 2'd2) begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    // output side
    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = queue_reg[rd_ptr_reg].crc;
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // accept only when two more results still fit behind the byte in flight
    assign inflight = QCNT_W'(n_push);
    assign s_tready = ((q_count_reg + inflight) <= QCNT_W'(QDEPTH - 2));

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // image end returns crc and count to start values
    a_image_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && done) |=> (bytes_reg == '0 && crc_reg == CRC_PRESET
                                    && chunk_cnt_reg == '0))
        else $error("state not restarted after verdict");

    // count never reaches all ones because that always ends the image
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_reg != {COUNT_W{1'b1}})
        else $error("byte count at its ceiling");

    // chunk counter tracks the byte count
    a_chunk_track: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(chunk_cnt_reg) == (32'(bytes_reg) % CHUNK_BYTES))
        else $error("chunk counter out of step");

    // a verdict follows its chunk acknowledge in the same queue write
    a_verdict_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_push == 2'd2) |=> (queue_reg[$past(wr_ptr_reg)].kind == KIND_CHUNK_ACK
                              && !queue_reg[$past(wr_ptr_reg)].last))
        else $error("verdict not preceded by acknowledge");

endmodule
